[design/kmd_pkg.sv]
// Shared types and constants for the k-way merge with duplicate removal.
package kmd_pkg;

	localparam int DEF_SOURCES   = 8;
	localparam int DEF_KEY_WIDTH = 32;
	localparam int DEF_SEQ_WIDTH = 32;

	// Width of the source number carried on the channels.
	localparam int SRC_WIDTH = 3;

	// Word operation codes.
	localparam logic OP_ROW = 1'b0;
	localparam logic OP_END = 1'b1;

	// Configuration register map: register index is paddr[2].
	localparam int   CFG_ADDR_WIDTH = 3;
	localparam logic REG_UNIQUE     = 1'b0;
	localparam logic REG_SEQ_EN     = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic apply;      // input word accepted: update heads and end marks
		logic scan_init;  // restart the winner search
		logic scan_step;  // read the next head and advance the scan index
		logic pop_load;   // pop the winner into the output register
		logic done_load;  // load a done word into the output register
	} kmd_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic all_ready;  // every source holds a head or has ended
		logic any_head;   // at least one head is held
		logic scan_last;  // scan index points at the last source
		logic out_free;   // output register can take a word this cycle
	} kmd_stat_t;

endpackage

[design/kmd_if.sv]
// Handshake channels for input words and result words.
interface kmd_in_if
	import kmd_pkg::*;
#(
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) ();
	typedef struct packed {
		logic                 operation;
		logic [SRC_WIDTH-1:0] source;
		logic [KEY_WIDTH-1:0] row_key;
		logic [SEQ_WIDTH-1:0] row_sequence;
	} word_t;

	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kmd_out_if
	import kmd_pkg::*;
#(
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) ();
	typedef struct packed {
		logic                 emit_valid;
		logic [KEY_WIDTH-1:0] out_key;
		logic [SEQ_WIDTH-1:0] out_sequence;
		logic [SRC_WIDTH-1:0] out_source;
		logic [SRC_WIDTH-1:0] refill_source;
		logic                 done_res;
	} word_t;

	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/kmd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kmd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/kmd_ctrl.sv]
// Sequencer for one input word: update, readiness check, winner scan, pop or done word.
module kmd_ctrl
	import kmd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  kmd_stat_t stat,
	output kmd_cmd_t  cmd
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_POP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.apply     = in_valid && in_ready_q;
			ST_CHECK: cmd.scan_init = stat.all_ready && stat.any_head;
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_POP:   cmd.pop_load  = stat.out_free;
			ST_DONE:  cmd.done_load = stat.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_CHECK;
						in_ready_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					if (!stat.all_ready) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end else if (!stat.any_head) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_POP;
				ST_POP, ST_DONE: begin
					if (stat.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end
endmodule

[design/kmd_dp.sv]
// Head store, winner search, duplicate filter and output register.
module kmd_dp
	import kmd_pkg::*;
#(
	parameter int SOURCES   = DEF_SOURCES,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kmd_cmd_t             cmd,
	output kmd_stat_t            stat,
	input  logic                 unique_mode,
	input  logic                 sequence_enable,
	input  logic                 operation,
	input  logic [SRC_WIDTH-1:0] source,
	input  logic [KEY_WIDTH-1:0] row_key,
	input  logic [SEQ_WIDTH-1:0] row_sequence,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 emit_valid,
	output logic [KEY_WIDTH-1:0] out_key,
	output logic [SEQ_WIDTH-1:0] out_sequence,
	output logic [SRC_WIDTH-1:0] out_source,
	output logic [SRC_WIDTH-1:0] refill_source,
	output logic                 done_res
);
	localparam int IDX_W = $clog2(SOURCES);
	localparam int ROW_W = KEY_WIDTH + SEQ_WIDTH;

	logic [SOURCES-1:0]   present_q;
	logic [SOURCES-1:0]   ended_q;
	logic [KEY_WIDTH-1:0] last_key_q;
	logic                 have_emitted_q;

	logic [IDX_W-1:0]     scan_idx_q;
	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [ROW_W-1:0]     rd_row;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [SEQ_WIDTH-1:0] rd_seq;

	logic                 best_valid_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [KEY_WIDTH-1:0] best_key_q;
	logic [SEQ_WIDTH-1:0] best_seq_q;

	logic                 out_valid_q;
	logic                 emit_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [SEQ_WIDTH-1:0] out_seq_q;
	logic [SRC_WIDTH-1:0] out_src_q;
	logic [SRC_WIDTH-1:0] refill_q;
	logic                 done_q;

	logic             in_range;
	logic [IDX_W-1:0] in_idx;
	logic             row_write;
	logic             end_write;
	logic             take;
	logic             beats;
	logic             dup;

	assign in_range  = 32'(source) < 32'(SOURCES);
	assign in_idx    = IDX_W'(source);
	assign row_write = cmd.apply && in_range && (operation == OP_ROW)
		&& !present_q[in_idx] && !ended_q[in_idx];
	assign end_write = cmd.apply && in_range && (operation == OP_END)
		&& !present_q[in_idx];

	kmd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SOURCES)
	) u_heads (
		.clk   (clk),
		.we    (row_write),
		.waddr (in_idx),
		.wdata ({row_key, row_sequence}),
		.re    (cmd.scan_step),
		.raddr (scan_idx_q),
		.rdata (rd_row)
	);

	assign rd_key = rd_row[ROW_W-1:SEQ_WIDTH];
	assign rd_seq = rd_row[SEQ_WIDTH-1:0];

	// Scan visits sources in ascending order, so a full tie goes to the newcomer.
	always_comb begin
		if (rd_key != best_key_q) begin
			beats = rd_key < best_key_q;
		end else if (sequence_enable && (rd_seq != best_seq_q)) begin
			beats = rd_seq > best_seq_q;
		end else begin
			beats = 1'b1;
		end
	end

	assign take = rd_valid_s1 && present_q[rd_idx_s1] && (!best_valid_q || beats);
	assign dup  = unique_mode && have_emitted_q && (best_key_q == last_key_q);

	assign stat.all_ready = &(present_q | ended_q);
	assign stat.any_head  = |present_q;
	assign stat.scan_last = scan_idx_q == IDX_W'(SOURCES - 1);
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q      <= '0;
			ended_q        <= '0;
			have_emitted_q <= 1'b0;
			last_key_q     <= '0;
			scan_idx_q     <= '0;
			rd_valid_s1    <= 1'b0;
			best_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (row_write) begin
				present_q[in_idx] <= 1'b1;
			end
			if (end_write) begin
				ended_q[in_idx] <= 1'b1;
			end

			rd_valid_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				scan_idx_q   <= '0;
				best_valid_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (take) begin
				best_valid_q <= 1'b1;
			end

			if (cmd.pop_load) begin
				present_q[best_idx_q] <= 1'b0;
				if (!dup) begin
					last_key_q     <= best_key_q;
					have_emitted_q <= 1'b1;
				end
			end

			if (cmd.pop_load || cmd.done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_key_q <= rd_key;
			best_seq_q <= rd_seq;
		end
		if (cmd.pop_load) begin
			emit_q    <= !dup;
			out_key_q <= dup ? '0 : best_key_q;
			out_seq_q <= dup ? '0 : best_seq_q;
			out_src_q <= SRC_WIDTH'(best_idx_q);
			refill_q  <= SRC_WIDTH'(best_idx_q);
			done_q    <= 1'b0;
		end else if (cmd.done_load) begin
			emit_q    <= 1'b0;
			out_key_q <= '0;
			out_seq_q <= '0;
			out_src_q <= '0;
			refill_q  <= '0;
			done_q    <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign emit_valid    = emit_q;
	assign out_key       = out_key_q;
	assign out_sequence  = out_seq_q;
	assign out_source    = out_src_q;
	assign refill_source = refill_q;
	assign done_res      = done_q;
endmodule

[design/kway_merge_dedup.sv]
// Top level of the k-way sorted merge with optional duplicate-key removal.
//
// in_ch carries one word per handshake: a row (key, sequence) for a source,
// or an end mark for a source. Each source first sends one row or end mark;
// once every live source holds a head row, the smallest key is popped (ties:
// larger sequence when sequence_enable is set, then higher source number).
// The popped word names the source in refill_source: send that source's next
// row or its end mark next. In unique mode a popped row whose key repeats
// the last emitted key comes out with emit_valid low. With all sources ended
// every input word returns a word with done_res set.
// Per word: accept, then the readiness check; a word that completes no pop
// ends there, a done word is loaded after it, and for a pop the winner search
// reads one head per cycle from the head RAM and compares it against the
// best so far, then a drain state, then the pop into the output register.
// One word is in work at a time; the result waits in an output register,
// and a stalled receiver holds the block only when the next result is
// ready to load. Reset clears all head and end flags, the duplicate filter
// and both configuration bits. Configuration writes go through the APB
// port, at byte address 0 (unique_mode) and 4 (sequence_enable); the user
// must write them only while idle: the block itself does not enforce it.
module kway_merge_dedup
	import kmd_pkg::*;
#(
	parameter int SOURCES   = DEF_SOURCES,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH,
	parameter int SEQ_WIDTH = DEF_SEQ_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	kmd_in_if.sink                    in_ch,
	kmd_out_if.source                 out_ch
);
	logic      unique_q;
	logic      seq_en_q;
	kmd_cmd_t  cmd;
	kmd_stat_t stat;

	// Configuration registers: every write completes in its access cycle.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_q <= 1'b0;
			seq_en_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_UNIQUE: unique_q <= pwdata[0];
				REG_SEQ_EN: seq_en_q <= pwdata[0];
				default:    unique_q <= unique_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_UNIQUE: prdata = {31'b0, unique_q};
			REG_SEQ_EN: prdata = {31'b0, seq_en_q};
			default:    prdata = '0;
		endcase
	end

	// Sequencer: accept one word, then check readiness, scan, pop or load a done word.
	kmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Heads, winner search, duplicate filter and the output register.
	kmd_dp #(
		.SOURCES   (SOURCES),
		.KEY_WIDTH (KEY_WIDTH),
		.SEQ_WIDTH (SEQ_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.unique_mode     (unique_q),
		.sequence_enable (seq_en_q),
		.operation       (in_ch.data.operation),
		.source          (in_ch.data.source),
		.row_key         (in_ch.data.row_key),
		.row_sequence    (in_ch.data.row_sequence),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.emit_valid      (out_ch.data.emit_valid),
		.out_key         (out_ch.data.out_key),
		.out_sequence    (out_ch.data.out_sequence),
		.out_source      (out_ch.data.out_source),
		.refill_source   (out_ch.data.refill_source),
		.done_res        (out_ch.data.done_res)
	);
endmodule

[verif/tb_top.sv]
// Self-checking testbench for the k-way merge with duplicate removal.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kmd_pkg::*;

	localparam int NSRC        = DEF_SOURCES;
	localparam int KW          = DEF_KEY_WIDTH;
	localparam int SW          = DEF_SEQ_WIDTH;
	// Settle time covers a full pop; leave margin for the output register.
	localparam int SETTLE      = NSRC + 8;
	localparam int HOLD_CYCLES = 400;

	// Same layout as the channel words, declared here so the testbench owns its types.
	typedef struct packed {
		logic                 operation;
		logic [SRC_WIDTH-1:0] source;
		logic [KW-1:0]        row_key;
		logic [SW-1:0]        row_sequence;
	} row_word_t;

	typedef struct packed {
		logic                 emit_valid;
		logic [KW-1:0]        out_key;
		logic [SW-1:0]        out_sequence;
		logic [SRC_WIDTH-1:0] out_source;
		logic [SRC_WIDTH-1:0] refill_source;
		logic                 done_res;
	} merge_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [CFG_ADDR_WIDTH-1:0] paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	kmd_in_if  #(.KEY_WIDTH(KW), .SEQ_WIDTH(SW)) in_ch ();
	kmd_out_if #(.KEY_WIDTH(KW), .SEQ_WIDTH(SW)) out_ch ();

	kway_merge_dedup #(
		.SOURCES  (NSRC),
		.KEY_WIDTH(KW),
		.SEQ_WIDTH(SW)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Merge predictor: head rows, end flags, duplicate filter, config bits
	// ------------------------------------------------------------------
	logic [KW-1:0] held_key [NSRC];
	logic [SW-1:0] held_seq [NSRC];
	bit            held     [NSRC];
	bit            ended    [NSRC];
	logic [KW-1:0] last_key;
	bit            any_emitted;
	bit            cfg_unique;
	bit            cfg_seq_first;

	// Expected output words, oldest first.
	merge_word_t merged_q[$];

	// Stimulus controls: input gaps for the sender, stalls and hold-off for the receiver process.
	bit in_gaps    = 1'b1;
	bit out_stalls = 1'b1;
	int hold_req   = 0;

	int fail_cnt   = 0;
	int n_words    = 0;
	int n_emitted  = 0;
	int n_dropped  = 0;
	int n_done     = 0;

	// Per-phase key stream: every source climbs slowly above a shared base, so
	// heads interleave and collide on equal keys.
	logic [KW-1:0] key_base;
	int            key_off [NSRC];

	// True when head a leaves before head b.
	function automatic bit outranks(input int a, input int b);
		if (held_key[a] != held_key[b])
			return held_key[a] < held_key[b];
		if (cfg_seq_first && held_seq[a] != held_seq[b])
			return held_seq[a] > held_seq[b];
		return a > b;
	endfunction

	// Apply one accepted word and queue the word it causes, if any.
	task automatic merge_predict(input row_word_t w);
		int          s;
		int          best;
		bit          all_in;
		bit          any_head;
		merge_word_t r;

		s        = int'(w.source);
		best     = -1;
		all_in   = 1'b1;
		any_head = 1'b0;
		r        = '0;

		// Rows land only in an empty, live slot; an end mark only on a source
		// with no head.
		if (s < NSRC) begin
			if (w.operation == OP_ROW) begin
				if (!held[s] && !ended[s]) begin
					held_key[s] = w.row_key;
					held_seq[s] = w.row_sequence;
					held[s]     = 1'b1;
				end
			end else if (!held[s]) begin
				ended[s] = 1'b1;
			end
		end

		for (int i = 0; i < NSRC; i++) begin
			if (held[i]) begin
				any_head = 1'b1;
				if (best < 0 || outranks(i, best))
					best = i;
			end else if (!ended[i]) begin
				all_in = 1'b0;
			end
		end

		// Some live source still owes a row: nothing comes out.
		if (all_in) begin
			if (!any_head) begin
				r.done_res = 1'b1;
			end else begin
				held[best]      = 1'b0;
				r.out_source    = SRC_WIDTH'(best);
				r.refill_source = SRC_WIDTH'(best);
				// In unique mode a repeat of the last emitted key comes out with emit_valid low.
				if (!(cfg_unique && any_emitted && held_key[best] == last_key)) begin
					r.emit_valid   = 1'b1;
					r.out_key      = held_key[best];
					r.out_sequence = held_seq[best];
					last_key       = held_key[best];
					any_emitted    = 1'b1;
				end
			end
			merged_q.push_back(r);
		end
	endtask

	// Lowest source that owes a row or end mark; -1 once all have ended.
	function automatic int pending_source();
		for (int i = 0; i < NSRC; i++)
			if (!held[i] && !ended[i])
				return i;
		return -1;
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < NSRC; i++)
			if (!ended[i])
				n++;
		return n;
	endfunction

	// Mostly short pauses, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(15, 50);
		return $urandom_range(1, 3);
	endfunction

	// Small sequences make ties on equal keys likely.
	function automatic logic [SW-1:0] pick_seq();
		if ($urandom_range(0, 1) == 0)
			return SW'($urandom());
		return SW'($urandom_range(0, 3));
	endfunction

	// ------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_cnt++;
		if (fail_cnt <= 30)
			$display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Input side: one word per call, valid held high across back-to-back words
	// ------------------------------------------------------------------
	task automatic send_word(input logic op, input int src, input logic [KW-1:0] key,
			input logic [SW-1:0] seq);
		row_word_t w;
		int        gap;

		w.operation    = op;
		w.source       = SRC_WIDTH'(src);
		w.row_key      = key;
		w.row_sequence = seq;
		gap = (in_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		merge_predict(w);
		n_words++;
	endtask

	// Next row for the source the block asked for.
	task automatic send_refill(input logic [KW-1:0] key, input logic [SW-1:0] seq);
		send_word(OP_ROW, pending_source(), key, seq);
	endtask

	// A word the block must ignore: row or end mark for a source that holds a
	// head or has ended.
	task automatic send_noise();
		int s;
		s = $urandom_range(0, NSRC - 1);
		if (held[s] || ended[s])
			send_word(logic'($urandom_range(0, 1)), s, KW'($urandom()), SW'($urandom()));
	endtask

	// Drop valid, drain all expected words, then give the block time to settle.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (merged_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	task automatic reg_write(input logic idx, input bit val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		// Upper bits are don't-care for a one-bit register; toggle them anyway.
		pwdata  <= {31'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_UNIQUE)
			cfg_unique = val;
		else
			cfg_seq_first = val;
	endtask

	task automatic reg_read(input logic idx, input bit want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {31'b0, want})
			report_mismatch(idx == REG_UNIQUE ? "unique_mode readback" :
				"sequence_enable readback", prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input bit uniq, input bit seq_first);
		reg_write(REG_UNIQUE, uniq);
		reg_write(REG_SEQ_EN, seq_first);
		reg_read(REG_UNIQUE, uniq);
		reg_read(REG_SEQ_EN, seq_first);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin : rx_side
		int stall_left;
		int hold_left;
		bit nxt;

		out_ch.ready = 1'b0;
		stall_left   = 0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			nxt = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt = 1'b0;
			end else if (out_stalls && $urandom_range(0, 5) == 0) begin
				stall_left = gap_len() - 1;
				nxt        = 1'b0;
			end
			out_ch.ready <= nxt;
		end
	end

	// Compare every accepted output word against the oldest expectation.
	always @(posedge clk) begin : check_merged
		merge_word_t got;
		merge_word_t want;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (merged_q.size() == 0) begin
				report_mismatch("output word with none expected", got.out_key, 0);
			end else begin
				want = merged_q[0];
				merged_q.delete(0);
				if (got.emit_valid !== want.emit_valid)
					report_mismatch("emit_valid", got.emit_valid, want.emit_valid);
				if (got.out_key !== want.out_key)
					report_mismatch("out_key", got.out_key, want.out_key);
				if (got.out_sequence !== want.out_sequence)
					report_mismatch("out_sequence", got.out_sequence, want.out_sequence);
				if (got.out_source !== want.out_source)
					report_mismatch("out_source", got.out_source, want.out_source);
				if (got.refill_source !== want.refill_source)
					report_mismatch("refill_source", got.refill_source, want.refill_source);
				if (got.done_res !== want.done_res)
					report_mismatch("done_res", got.done_res, want.done_res);
				if (want.done_res)
					n_done++;
				else if (want.emit_valid)
					n_emitted++;
				else
					n_dropped++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values read back, then unique_mode written both ways and sequence_enable written high.
	task automatic test_registers();
		reg_read(REG_UNIQUE, 1'b0);
		reg_read(REG_SEQ_EN, 1'b0);
		set_config(1'b1, 1'b1);
		set_config(1'b0, 1'b1);
	endtask

	// Fill every source, with ignored words mixed in before the block is ready,
	// and heads that tie on key, on key and sequence, and sit at both key extremes.
	task automatic test_fill_and_ties();
		send_word(OP_ROW, 0, 5, 1);
		send_word(OP_ROW, 0, 9, 9);           // source already holds a head: ignore
		send_word(OP_END, 0, 0, 0);           // end mark with a head held: ignore
		send_word(OP_ROW, 1, 5, 9);
		send_word(OP_ROW, 2, 5, 9);           // same key and sequence as source 1
		send_word(OP_ROW, 3, 0, '1);
		send_word(OP_ROW, 4, '1, 0);
		send_word(OP_ROW, 5, 5, 0);
		send_word(OP_ROW, 6, 7, 7);
		send_word(OP_ROW, 7, 7, 7);           // last head in: first pop
		send_refill(5, 3);
		send_refill(5, 9);
		send_refill(7, 7);
		send_refill(7, '1);
	endtask

	// Unique mode: refill with the last emitted key so the winner repeats it.
	task automatic test_duplicate_drop();
		wait_idle();
		set_config(1'b1, 1'b0);
		repeat (5) send_refill(last_key, SW'($urandom()));
		// End one source early, then send a word that the block must ignore.
		send_word(OP_END, pending_source(), 0, 0);
		send_noise();
		send_refill(last_key + 1, 0);
	endtask

	// Long random merge in phases, one config setting per phase.
	task automatic test_random_merge();
		bit uniq_set [5]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		bit seq_set  [5]  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
		int s;
		int sent;

		key_base = '0;
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			set_config(uniq_set[p], seq_set[p]);
			// One phase runs without any pauses on either side.
			in_gaps    = (p != 2);
			out_stalls = (p != 2);
			key_base  += KW'($urandom_range(1, 32'h2800_0000));
			foreach (key_off[i])
				key_off[i] = 0;
			sent = 0;
			while (sent < 310) begin
				s = pending_source();
				if (s < 0)
					break;
				if ($urandom_range(0, 9) == 0) begin
					send_noise();
				end else begin
					if ($urandom_range(0, 299) == 0 && live_count() > 4) begin
						send_word(OP_END, s, KW'($urandom()), SW'($urandom()));
					end else begin
						key_off[s] += $urandom_range(0, 2);
						send_word(OP_ROW, s, key_base + KW'(key_off[s]), pick_seq());
					end
					sent++;
				end
			end
		end
		in_gaps    = 1'b1;
		out_stalls = 1'b1;
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering refills.
	task automatic test_backpressure();
		in_gaps  = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (40) begin
			key_off[0] += $urandom_range(0, 2);
			send_refill(key_base + KW'(key_off[0]), pick_seq());
		end
		in_gaps = 1'b1;
	endtask

	// End every source, then confirm that any further word only reports done.
	task automatic test_drain_and_done();
		int s;

		s = pending_source();
		while (s >= 0) begin
			send_word(OP_END, s, KW'($urandom()), SW'($urandom()));
			s = pending_source();
		end
		repeat (6)
			send_word(logic'($urandom_range(0, 1)), $urandom_range(0, NSRC - 1),
				KW'($urandom()), SW'($urandom()));
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------
	initial begin : run
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		last_key    = '0;
		any_emitted = 1'b0;
		cfg_unique  = 1'b0;
		cfg_seq_first = 1'b0;
		foreach (held[i]) begin
			held[i]     = 1'b0;
			ended[i]    = 1'b0;
			held_key[i] = '0;
			held_seq[i] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_fill_and_ties();
		test_duplicate_drop();
		test_random_merge();
		test_backpressure();
		test_drain_and_done();
		wait_idle();

		$display("Sent %0d words; checked %0d emitted, %0d dropped, %0d done.",
			n_words, n_emitted, n_dropped, n_done);
		$display("Covered all config settings, end marks, ignored words, %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches found", fail_cnt);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin : watchdog
		#5ms;
		$display("Timeout: merge traffic stopped with %0d words still expected", merged_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[kway_merge_dedup.f]
design/kmd_pkg.sv
design/kmd_if.sv
design/kmd_ram.sv
design/kmd_ctrl.sv
design/kmd_dp.sv
design/kway_merge_dedup.sv
verif/tb_top.sv
